>>> rtl/gbns_pkg.sv
// Package: request/result types and codes for the go-back-N sender window.
`timescale 1ns / 1ps
package gbns_pkg;

	localparam int TIME_W    = 16;
	localparam int WIN_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	typedef enum logic [1:0] {
		OP_ARRIVE = 2'd0,
		OP_ACK    = 2'd1,
		OP_TICK   = 2'd2,
		OP_SLOT   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ACK_IGN   = 3'd1,
		ST_ACK_EMPTY = 3'd2,
		ST_FULL      = 3'd3,
		ST_NO_SEND   = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW  = 1'b0,
		CFG_TIMEOUT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] ack_seq;
	} req_t;

	typedef struct packed {
		logic        tx_valid;
		logic [15:0] tx_seq;
		logic        timed_out;
		status_t     status;
		logic [6:0]  in_flight;
		logic [10:0] backlog;
	} res_t;

endpackage

>>> rtl/go_back_n_sender_window_core.sv
// Top level: request/result registers, configuration registers, window core.
`timescale 1ns / 1ps
// Go-back-N sender window. Each request is one event (packet arrival, ack,
// time tick or send slot) and gives exactly one result. One request is taken
// every cycle at full rate unless out_ready holds back a waiting result; a
// result passes the input register, then the result register, and is held
// there until taken. The whole window update,
// including the timeout compare against the base packet's send time, runs in
// one pass; that send time is held in a register refilled from the prefetched
// next ring entry, so back-to-back acks and ticks need no stall. The send-time
// ring needs no clearing after reset. Configuration is taken at any time but
// should only be written while the block is idle; unknown indexes are ignored.
module go_back_n_sender_window_core #(
	parameter int MAX_WINDOW  = 64,
	parameter int SEQ_BITS    = 16,
	parameter int MAX_BACKLOG = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  gbns_pkg::req_t                       in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output gbns_pkg::res_t                       out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gbns_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gbns_pkg::CFG_DAT_W-1:0]       cfg_data
);
	import gbns_pkg::*;

	req_t        req_s1;
	logic        vld_s1;
	res_t        res_c;
	res_t        res_s2;
	logic        vld_s2;
	logic        advance;
	logic [6:0]  win_q;
	logic [15:0] tmo_q;

	assign advance   = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready  = !vld_s1 || advance;
	assign out_valid = vld_s2;
	assign out_data  = res_s2;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (advance) begin
				vld_s2 <= 1'b1;
			end else if (out_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
		if (advance) begin
			res_s2 <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 7'd8;
			tmo_q <= 16'd12;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WINDOW:  win_q <= cfg_data[6:0];
				CFG_TIMEOUT: tmo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gbns_window #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SEQ_BITS    (SEQ_BITS),
		.MAX_BACKLOG (MAX_BACKLOG)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.req     (req_s1),
		.win_cfg (win_q),
		.tmo_cfg (tmo_q),
		.res     (res_c)
	);

endmodule

>>> rtl/gbns_time_ram.sv
// Send-time ring memory: one write port, one registered read port with write bypass.
`timescale 1ns / 1ps
module gbns_time_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data <= wr_data;
		end else begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/gbns_window.sv
// Window state and single-pass event update for the go-back-N sender.
`timescale 1ns / 1ps
module gbns_window #(
	parameter int MAX_WINDOW  = 64,
	parameter int SEQ_BITS    = 16,
	parameter int MAX_BACKLOG = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  gbns_pkg::req_t        req,
	input  logic [6:0]            win_cfg,
	input  logic [15:0]           tmo_cfg,
	output gbns_pkg::res_t        res
);
	import gbns_pkg::*;

	localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam longint SEQ_MAX = (64'd1 << SEQ_BITS) - 64'd1;
	localparam longint LIMIT_V = (longint'(MAX_BACKLOG) < SEQ_MAX) ?
		longint'(MAX_BACKLOG) : SEQ_MAX;
	localparam logic [SEQ_BITS-1:0] LIMIT = SEQ_BITS'(LIMIT_V);
	localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_WINDOW - 1);
	localparam logic [SW:0] DEPTH_X = (SW + 1)'(MAX_WINDOW);

	logic [SEQ_BITS-1:0] base_q, next_send_q, next_gen_q;
	logic [SEQ_BITS-1:0] base_d, next_send_d, next_gen_d;
	logic [TIME_W-1:0]   cur_time_q, cur_time_d, base_time_q, base_time_d;
	logic [SW-1:0]       base_slot_q, base_slot_d, rd_addr;
	logic [TIME_W-1:0]   nxt_time, elapsed;
	logic [SEQ_BITS-1:0] flight, backlog_c, gen_cnt, ack_x, win_x;
	logic [WIN_W-1:0]    win;
	logic [SW:0]         wr_sum;
	logic [SW-1:0]       wr_addr;
	logic                wr_en;
	res_t                res_c;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	assign flight    = next_send_q - base_q;
	assign backlog_c = next_gen_q - next_send_q;
	assign gen_cnt   = next_gen_q - base_q;
	assign ack_x     = SEQ_BITS'(req.ack_seq);
	assign win       = (32'(win_cfg) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : win_cfg;
	assign win_x     = SEQ_BITS'(win);
	assign elapsed   = cur_time_q + 1'b1 - base_time_q;

	assign wr_sum  = {1'b0, base_slot_q} + (SW + 1)'(flight);
	assign wr_addr = (wr_sum >= DEPTH_X) ? SW'(wr_sum - DEPTH_X) : wr_sum[SW-1:0];

	always_comb begin
		base_d      = base_q;
		next_send_d = next_send_q;
		next_gen_d  = next_gen_q;
		cur_time_d  = cur_time_q;
		base_slot_d = base_slot_q;
		base_time_d = base_time_q;
		wr_en       = 1'b0;
		res_c           = '0;
		res_c.status    = ST_OK;
		unique case (req.op)
			OP_ARRIVE: begin
				if (gen_cnt >= LIMIT) begin
					res_c.status = ST_FULL;
				end else begin
					next_gen_d = next_gen_q + 1'b1;
				end
			end
			OP_ACK: begin
				if (flight == '0) begin
					res_c.status = ST_ACK_EMPTY;
				end else if (ack_x == base_q) begin
					base_d      = base_q + 1'b1;
					base_slot_d = slot_inc(base_slot_q);
					base_time_d = nxt_time;
				end else begin
					res_c.status = ST_ACK_IGN;
				end
			end
			OP_TICK: begin
				cur_time_d = cur_time_q + 1'b1;
				if (flight != '0 && elapsed >= tmo_cfg) begin
					next_send_d     = base_q;
					res_c.timed_out = 1'b1;
				end
			end
			OP_SLOT: begin
				if (backlog_c != '0 && flight < win_x) begin
					wr_en          = step;
					res_c.tx_valid = 1'b1;
					res_c.tx_seq   = 16'(next_send_q);
					next_send_d    = next_send_q + 1'b1;
					if (flight == '0) begin
						base_time_d = cur_time_q;
					end
				end else begin
					res_c.status = ST_NO_SEND;
				end
			end
			default: ;
		endcase
		res_c.in_flight = 7'(next_send_d - base_d);
		res_c.backlog   = 11'(next_gen_d - next_send_d);
	end

	assign res     = res_c;
	// keep the entry after the base prefetched for the next ack
	assign rd_addr = step ? slot_inc(base_slot_d) : slot_inc(base_slot_q);

	gbns_time_ram #(
		.DEPTH (MAX_WINDOW),
		.AW    (SW),
		.DW    (TIME_W)
	) u_time_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (cur_time_q),
		.rd_addr (rd_addr),
		.rd_data (nxt_time)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			next_send_q <= '0;
			next_gen_q  <= '0;
			cur_time_q  <= '0;
			base_slot_q <= '0;
		end else if (step) begin
			base_q      <= base_d;
			next_send_q <= next_send_d;
			next_gen_q  <= next_gen_d;
			cur_time_q  <= cur_time_d;
			base_slot_q <= base_slot_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			base_time_q <= base_time_d;
		end
	end

endmodule

>>> test/go_back_n_sender_window_core_test.sv
// Self-checking testbench for the go-back-N sender window core.
`timescale 1ns / 1ps
module go_back_n_sender_window_core_test;
	import gbns_pkg::*;

	localparam logic [15:0] BACKLOG_CAP = 16'd1024;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		op_t         op;
		logic [15:0] ack;
		int          reps;
		bit          typed;
		res_t        want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	res_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	// window state mirror
	logic [15:0] w_base, w_send, w_gen, w_now;
	logic [15:0] w_sent_at [64];
	logic [5:0] w_base_slot;
	logic [6:0] win_reg;
	logic [15:0] tmo_reg;

	res_t event_outcomes [$];
	dir_row_t dir_tab [$];
	int n_err = 0;
	int idle_cycles = 0;
	int in_calm = 0;
	int rx_calm = 0;
	int rx_hold = 0;

	go_back_n_sender_window_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report(string msg);
		if (n_err < 200) $display("MISMATCH @%0t: %s", $time, msg);
		n_err++;
	endtask

	function automatic res_t advance_window(req_t r);
		res_t o;
		logic [15:0] flight, unsent, held, age;
		logic [6:0] win;
		logic [5:0] slot;
		flight = w_send - w_base;
		unsent = w_gen - w_send;
		held = w_gen - w_base;
		win = (win_reg > 7'd64) ? 7'd64 : win_reg;
		o = '0;
		o.status = ST_OK;
		case (r.op)
		OP_ARRIVE: begin
			if (held >= BACKLOG_CAP) o.status = ST_FULL;
			else w_gen = w_gen + 16'd1;
		end
		OP_ACK: begin
			if (flight == 16'd0) begin
				o.status = ST_ACK_EMPTY;
			end else if (r.ack_seq == w_base) begin
				w_base = w_base + 16'd1;
				w_base_slot = w_base_slot + 6'd1;
			end else begin
				o.status = ST_ACK_IGN;
			end
		end
		OP_TICK: begin
			w_now = w_now + 16'd1;
			if (flight != 16'd0) begin
				age = w_now - w_sent_at[w_base_slot];
				if (age >= tmo_reg) begin
					w_send = w_base;
					o.timed_out = 1'b1;
				end
			end
		end
		default: begin
			if (unsent != 16'd0 && flight < {9'd0, win}) begin
				slot = w_base_slot + flight[5:0];
				w_sent_at[slot] = w_now;
				o.tx_valid = 1'b1;
				o.tx_seq = w_send;
				w_send = w_send + 16'd1;
			end else begin
				o.status = ST_NO_SEND;
			end
		end
		endcase
		flight = w_send - w_base;
		unsent = w_gen - w_send;
		o.in_flight = flight[6:0];
		o.backlog = unsent[10:0];
		return o;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic req_t make_req(op_t op, logic [15:0] ack);
		req_t r;
		r.op = op;
		r.ack_seq = ack;
		return r;
	endfunction

	function automatic req_t pick_req();
		req_t r;
		int k;
		r = make_req(OP_TICK, 16'($urandom()));
		k = $urandom_range(0, 99);
		if (k < 30) begin
			r.op = OP_ARRIVE;
		end else if (k < 60) begin
			r.op = OP_SLOT;
		end else if (k < 85) begin
			r.op = OP_ACK;
			k = $urandom_range(0, 9);
			if (k < 7) r.ack_seq = w_base;
			else if (k == 7) r.ack_seq = w_base + 16'd1;
		end
		return r;
	endfunction

	function automatic dir_row_t row(op_t op, logic [15:0] ack, int reps, bit typed,
			logic txv, logic [15:0] txs, logic tmo, status_t st,
			logic [6:0] fl, logic [10:0] bl);
		dir_row_t d;
		d.op = op;
		d.ack = ack;
		d.reps = reps;
		d.typed = typed;
		d.want.tx_valid = txv;
		d.want.tx_seq = txs;
		d.want.timed_out = tmo;
		d.want.status = st;
		d.want.in_flight = fl;
		d.want.backlog = bl;
		return d;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic issue(req_t r, bit typed, res_t want);
		res_t p;
		int g;
		p = advance_window(r);
		if (typed) p = want;
		if (in_calm > 0) begin
			g = 0;
			in_calm--;
		end else begin
			g = gap_len();
			if ($urandom_range(0, 99) < 3) in_calm = $urandom_range(20, 80);
		end
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_data <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		event_outcomes.push_back(p);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (event_outcomes.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_WINDOW) win_reg = val[6:0];
		else tmo_reg = val;
		@(negedge clk);
	endtask

	task automatic configure(logic [6:0] win, logic [15:0] tmo);
		settle();
		write_reg(CFG_WINDOW, {9'($urandom()), win});
		write_reg(CFG_TIMEOUT, tmo);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			out_ready <= 1'b1;
			if (rx_calm > 0) rx_calm = rx_calm - 1;
			else if ($urandom_range(0, 99) < 2) rx_calm = $urandom_range(50, 300);
			else if ($urandom_range(0, 99) < 15) rx_hold = gap_len();
		end
	end

	always @(posedge clk) begin : rx_check
		res_t want;
		logic [15:0] got_f [6];
		logic [15:0] want_f [6];
		string names [6];
		names = '{"tx_valid", "tx_seq", "timed_out", "status", "in_flight", "backlog"};
		if (arst_n && out_valid && out_ready) begin
			if (event_outcomes.size() == 0) begin
				report($sformatf("result with no request pending: %p", out_data));
			end else begin
				want = event_outcomes.pop_front();
				got_f = '{out_data.tx_valid, out_data.tx_seq, out_data.timed_out,
					out_data.status, out_data.in_flight, out_data.backlog};
				want_f = '{want.tx_valid, want.tx_seq, want.timed_out,
					want.status, want.in_flight, want.backlog};
				for (int i = 0; i < 6; i++) begin
					if (got_f[i] !== want_f[i])
						report($sformatf("%s got %0h want %0h", names[i], got_f[i], want_f[i]));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [6:0] w;
		logic [15:0] t;
		w_base = '0;
		w_send = '0;
		w_gen = '0;
		w_now = '0;
		w_base_slot = '0;
		win_reg = 7'd8;
		tmo_reg = 16'd12;
		for (int i = 0; i < 64; i++) w_sent_at[i] = '0;

		// default window 8, timeout 12
		dir_tab.push_back(row(OP_ACK, 16'h0000, 1, 1'b1, 1'b0, 16'd0, 1'b0,
			ST_ACK_EMPTY, 7'd0, 11'd0));
		dir_tab.push_back(row(OP_SLOT, 16'hFFFF, 1, 1'b1, 1'b0, 16'd0, 1'b0,
			ST_NO_SEND, 7'd0, 11'd0));
		dir_tab.push_back(row(OP_TICK, 16'h0000, 1, 1'b1, 1'b0, 16'd0, 1'b0,
			ST_OK, 7'd0, 11'd0));
		dir_tab.push_back(row(OP_ARRIVE, 16'h0000, 1, 1'b1, 1'b0, 16'd0, 1'b0,
			ST_OK, 7'd0, 11'd1));
		dir_tab.push_back(row(OP_ARRIVE, 16'hFFFF, 1, 1'b1, 1'b0, 16'd0, 1'b0,
			ST_OK, 7'd0, 11'd2));
		dir_tab.push_back(row(OP_SLOT, 16'h0000, 1, 1'b1, 1'b1, 16'd0, 1'b0,
			ST_OK, 7'd1, 11'd1));
		dir_tab.push_back(row(OP_ACK, 16'hFFFF, 1, 1'b1, 1'b0, 16'd0, 1'b0,
			ST_ACK_IGN, 7'd1, 11'd1));
		dir_tab.push_back(row(OP_ACK, 16'h0000, 1, 1'b1, 1'b0, 16'd0, 1'b0,
			ST_OK, 7'd0, 11'd1));
		dir_tab.push_back(row(OP_SLOT, 16'h0000, 1, 1'b1, 1'b1, 16'd1, 1'b0,
			ST_OK, 7'd1, 11'd0));
		dir_tab.push_back(row(OP_SLOT, 16'h0000, 1, 1'b1, 1'b0, 16'd0, 1'b0,
			ST_NO_SEND, 7'd1, 11'd0));
		dir_tab.push_back(row(OP_TICK, 16'h5555, 11, 1'b0, 1'b0, 16'd0, 1'b0,
			ST_OK, 7'd0, 11'd0));
		// timeout expires: back to base
		dir_tab.push_back(row(OP_TICK, 16'hAAAA, 1, 1'b1, 1'b0, 16'd0, 1'b1,
			ST_OK, 7'd0, 11'd1));
		// ack after go-back sees nothing in flight
		dir_tab.push_back(row(OP_ACK, 16'h0001, 1, 1'b1, 1'b0, 16'd0, 1'b0,
			ST_ACK_EMPTY, 7'd0, 11'd1));
		dir_tab.push_back(row(OP_SLOT, 16'h0000, 1, 1'b1, 1'b1, 16'd1, 1'b0,
			ST_OK, 7'd1, 11'd0));
		dir_tab.push_back(row(OP_ACK, 16'h8000, 1, 1'b0, 1'b0, 16'd0, 1'b0,
			ST_OK, 7'd0, 11'd0));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (dir_tab[i]) begin
			repeat (dir_tab[i].reps)
				issue(make_req(dir_tab[i].op, dir_tab[i].ack), dir_tab[i].typed, dir_tab[i].want);
		end

		for (int p = 0; p < 7; p++) begin
			case (p)
			0: begin
				w = 7'd1;
				t = 16'd1;
			end
			1: begin
				w = 7'd64;
				t = 16'hFFFF;
			end
			2: begin
				w = 7'd0;
				t = 16'd0;
			end
			3: begin
				w = 7'h7F;
				t = 16'd3;
			end
			4: begin
				w = 7'd16;
				t = 16'd6;
			end
			default: begin
				w = 7'($urandom_range(1, 64));
				t = 16'($urandom_range(1, 40));
			end
			endcase
			configure(w, t);
			repeat (132) issue(pick_req(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (event_outcomes.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (n_err == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
